// ===== src/hex_element_map_and_jacobian_defines.svh =====
// Assertion macros shared by the hex element map and Jacobian RTL.
// No dependencies; included by modules that carry checks.
`ifndef HEX_ELEMENT_MAP_AND_JACOBIAN_DEFINES_SVH
`define HEX_ELEMENT_MAP_AND_JACOBIAN_DEFINES_SVH
`ifndef SYNTHESIS
`define HEMJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");
`define HEMJ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");
`else
`define HEMJ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HEMJ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/hemj_pkg.sv =====
// Shared types and constants for the hex element map and Jacobian block.
// No dependencies.
package hemj_pkg;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 160;
    localparam int DIGIT_BITS  = 8;

    localparam logic [7:0] CORNER_R = 8'b0110_0110;
    localparam logic [7:0] CORNER_S = 8'b1100_1100;
    localparam logic [7:0] CORNER_T = 8'b1111_0000;

    typedef enum logic [2:0] {
        SRC_FACTOR,
        SRC_PAIR,
        SRC_TRIPLE,
        SRC_COORD,
        SRC_JAC,
        SRC_MINOR
    } src_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SET,
        ACC_SET_NEG,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_PAIR,
        DST_TRIPLE,
        DST_GLOBAL,
        DST_JAC,
        DST_MINOR,
        DST_DET
    } dst_t;

    typedef struct packed {
        logic       node_wr;
        logic       capture;
        logic       load_a;
        logic       load_b;
        logic       mul_step;
        src_t       src;
        logic [4:0] idx;
        acc_op_t    acc_op;
        dst_t       dst;
        logic [3:0] dst_idx;
        logic       out_load;
    } cmd_t;

    function automatic logic corner_bit(input logic [1:0] axis, input logic [2:0] corner);
        logic b;
        case (axis)
            2'd0:    b = CORNER_R[corner];
            2'd1:    b = CORNER_S[corner];
            default: b = CORNER_T[corner];
        endcase
        return b;
    endfunction

    function automatic logic [4:0] factor_idx(input logic [1:0] axis,
                                              input logic [2:0] corner);
        logic b;
        b = corner_bit(axis, corner);
        return 5'({axis, b});
    endfunction

endpackage

// ===== src/hemj_ctrl.sv =====
// Sequencer for the hex element map and Jacobian block.
// Depends on hemj_pkg and hex_element_map_and_jacobian_defines.svh.
`include "hex_element_map_and_jacobian_defines.svh"

module hemj_ctrl #(
    parameter int STEPS = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output hemj_pkg::cmd_t  cmd
);

    localparam int SCW = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LDA  = 6'b000010,
        S_LDB  = 6'b000100,
        S_STEP = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        PH_POINT = 4'b0001,
        PH_JAC   = 4'b0010,
        PH_MINOR = 4'b0100,
        PH_DET   = 4'b1000
    } phase_t;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       sub_reg, sub_next;
    logic [2:0]       corner_reg, corner_next;
    logic [1:0]       row_reg, row_next;
    logic [1:0]       col_reg, col_next;
    logic [SCW-1:0]   step_reg, step_next;
    logic             out_valid_reg, out_valid_next;

    hemj_pkg::src_t    src_a, src_b;
    logic [4:0]        idx_a, idx_b;
    hemj_pkg::acc_op_t op_acc;
    hemj_pkg::dst_t    op_dst;
    logic [3:0]        op_dst_idx;
    logic              last_sub;
    logic              last_op;
    logic              plus;
    logic [4:0]        coord_addr;
    logic              out_free;

    assign coord_addr = 5'(corner_reg) * 5'd3 + 5'(col_reg);
    assign plus       = hemj_pkg::corner_bit(row_reg, corner_reg);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        src_a      = hemj_pkg::SRC_FACTOR;
        src_b      = hemj_pkg::SRC_FACTOR;
        idx_a      = '0;
        idx_b      = '0;
        op_acc     = hemj_pkg::ACC_HOLD;
        op_dst     = hemj_pkg::DST_NONE;
        op_dst_idx = '0;
        last_sub   = 1'b0;
        unique case (phase_reg)
            PH_POINT:
            begin
                last_sub = (sub_reg == 2'd2);
                unique case (sub_reg)
                    2'd0:
                    begin
                        idx_a  = hemj_pkg::factor_idx(2'd0, corner_reg);
                        idx_b  = hemj_pkg::factor_idx(2'd1, corner_reg);
                        op_dst = hemj_pkg::DST_PAIR;
                    end
                    2'd1:
                    begin
                        src_a  = hemj_pkg::SRC_PAIR;
                        idx_b  = hemj_pkg::factor_idx(2'd2, corner_reg);
                        op_dst = hemj_pkg::DST_TRIPLE;
                    end
                    default:
                    begin
                        src_a  = hemj_pkg::SRC_TRIPLE;
                        src_b  = hemj_pkg::SRC_COORD;
                        idx_b  = coord_addr;
                        op_acc = (corner_reg == 3'd0) ? hemj_pkg::ACC_SET : hemj_pkg::ACC_ADD;
                        if (corner_reg == 3'd7)
                        begin
                            op_dst     = hemj_pkg::DST_GLOBAL;
                            op_dst_idx = 4'(col_reg);
                        end
                    end
                endcase
            end
            PH_JAC:
            begin
                last_sub = (sub_reg == 2'd1);
                if (sub_reg == 2'd0)
                begin
                    idx_a  = hemj_pkg::factor_idx((row_reg == 2'd0) ? 2'd1 : 2'd0, corner_reg);
                    idx_b  = hemj_pkg::factor_idx((row_reg == 2'd2) ? 2'd1 : 2'd2, corner_reg);
                    op_dst = hemj_pkg::DST_PAIR;
                end
                else
                begin
                    src_a = hemj_pkg::SRC_PAIR;
                    src_b = hemj_pkg::SRC_COORD;
                    idx_b = coord_addr;
                    if (corner_reg == 3'd0)
                        op_acc = plus ? hemj_pkg::ACC_SET : hemj_pkg::ACC_SET_NEG;
                    else
                        op_acc = plus ? hemj_pkg::ACC_ADD : hemj_pkg::ACC_SUB;
                    if (corner_reg == 3'd7)
                    begin
                        op_dst     = hemj_pkg::DST_JAC;
                        op_dst_idx = 4'(row_reg) * 4'd3 + 4'(col_reg);
                    end
                end
            end
            PH_MINOR:
            begin
                last_sub = (sub_reg == 2'd1);
                src_a    = hemj_pkg::SRC_JAC;
                src_b    = hemj_pkg::SRC_JAC;
                case ({row_reg, sub_reg[0]})
                    3'b000:  begin idx_a = 5'd4; idx_b = 5'd8; end
                    3'b001:  begin idx_a = 5'd5; idx_b = 5'd7; end
                    3'b010:  begin idx_a = 5'd3; idx_b = 5'd8; end
                    3'b011:  begin idx_a = 5'd5; idx_b = 5'd6; end
                    3'b100:  begin idx_a = 5'd3; idx_b = 5'd7; end
                    default: begin idx_a = 5'd4; idx_b = 5'd6; end
                endcase
                if (sub_reg == 2'd0)
                    op_acc = hemj_pkg::ACC_SET;
                else
                begin
                    op_acc     = hemj_pkg::ACC_SUB;
                    op_dst     = hemj_pkg::DST_MINOR;
                    op_dst_idx = 4'(row_reg);
                end
            end
            PH_DET:
            begin
                last_sub = 1'b1;
                src_a    = hemj_pkg::SRC_MINOR;
                src_b    = hemj_pkg::SRC_JAC;
                idx_a    = 5'(row_reg);
                idx_b    = 5'(row_reg);
                case (row_reg)
                    2'd0:    op_acc = hemj_pkg::ACC_SET;
                    2'd1:    op_acc = hemj_pkg::ACC_SUB;
                    default:
                    begin
                        op_acc = hemj_pkg::ACC_ADD;
                        op_dst = hemj_pkg::DST_DET;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign last_op = (phase_reg == PH_DET) && (row_reg == 2'd2);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        corner_next    = corner_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_mode)
                begin
                    state_next  = S_LDA;
                    phase_next  = PH_POINT;
                    sub_next    = '0;
                    corner_next = '0;
                    row_next    = '0;
                    col_next    = '0;
                end
            end
            S_LDA:
                state_next = S_LDB;
            S_LDB:
            begin
                state_next = S_STEP;
                step_next  = '0;
            end
            S_STEP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == SCW'(STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = last_op ? S_DONE : S_LDA;
                sub_next   = last_sub ? 2'd0 : sub_reg + 2'd1;
                if (last_sub)
                begin
                    unique case (phase_reg)
                        PH_POINT, PH_JAC:
                        begin
                            corner_next = corner_reg + 3'd1;
                            if (corner_reg == 3'd7)
                            begin
                                col_next = (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                                if (col_reg == 2'd2)
                                begin
                                    if (phase_reg == PH_POINT)
                                        phase_next = PH_JAC;
                                    else
                                    begin
                                        row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                                        if (row_reg == 2'd2)
                                            phase_next = PH_MINOR;
                                    end
                                end
                            end
                        end
                        PH_MINOR:
                        begin
                            row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                            if (row_reg == 2'd2)
                                phase_next = PH_DET;
                        end
                        PH_DET:
                            row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_POINT;
            sub_reg       <= '0;
            corner_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            corner_reg    <= corner_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.node_wr  = (state_reg == S_IDLE) && in_valid && !in_mode;
        cmd.capture  = (state_reg == S_IDLE) && in_valid && in_mode;
        cmd.load_a   = (state_reg == S_LDA);
        cmd.load_b   = (state_reg == S_LDB);
        cmd.mul_step = (state_reg == S_STEP);
        cmd.src      = (state_reg == S_LDB) ? src_b : src_a;
        cmd.idx      = (state_reg == S_LDB) ? idx_b : idx_a;
        cmd.acc_op   = (state_reg == S_FIN) ? op_acc : hemj_pkg::ACC_HOLD;
        cmd.dst      = (state_reg == S_FIN) ? op_dst : hemj_pkg::DST_NONE;
        cmd.dst_idx  = op_dst_idx;
        cmd.out_load = (state_reg == S_DONE) && out_free;
    end

    `HEMJ_ASSERT_NXT(a_capture_to_load, clk, rst_n, cmd.capture, state_reg == S_LDA)
    `HEMJ_ASSERT_IMP(a_fin_after_step, clk, rst_n, state_reg == S_FIN, $past(state_reg) == S_STEP)
    `HEMJ_ASSERT_NXT(a_out_load_valid, clk, rst_n, cmd.out_load, out_valid_reg && state_reg == S_IDLE)
    `HEMJ_ASSERT_IMP(a_step_bound, clk, rst_n, state_reg == S_STEP, step_reg <= SCW'(STEPS - 1))

endmodule

// ===== src/hemj_dpath.sv =====
// Datapath: node store, shape factors, digit-serial multiplier, accumulator, rounding.
// Depends on hemj_pkg.
module hemj_dpath #(
    parameter int COORD_WIDTH     = 32,
    parameter int LOCAL_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hemj_pkg::cmd_t      cmd,
    input  logic [2:0]          node_index,
    input  logic signed [31:0]  node_x,
    input  logic signed [31:0]  node_y,
    input  logic signed [31:0]  node_z,
    input  logic signed [15:0]  local_r,
    input  logic signed [15:0]  local_s,
    input  logic signed [15:0]  local_t,
    output logic signed [31:0]  global_x,
    output logic signed [31:0]  global_y,
    output logic signed [31:0]  global_z,
    output logic signed [63:0]  jacobian_det,
    output logic                det_not_positive
);

    localparam int F     = LOCAL_FRAC_BITS;
    localparam int CW    = COORD_WIDTH;
    localparam int DB    = hemj_pkg::DIGIT_BITS;
    localparam int FS    = F + 3;
    localparam int QW    = 2 * F + 4;
    localparam int WW    = 3 * F + 5;
    localparam int JW    = CW + 4;
    localparam int MW    = 2 * JW + 1;
    localparam int AW    = (WW > MW) ? WW : MW;
    localparam int BW    = (JW > FS) ? JW : FS;
    localparam int STEPS = (BW + DB - 1) / DB;
    localparam int BX    = STEPS * DB;
    localparam int PW    = AW + BX;
    localparam int SW    = PW + 3;
    localparam int EW    = (SW > 64) ? SW + 1 : 65;
    localparam int LW    = (F + 3 > 17) ? F + 3 : 17;
    localparam int CX    = (CW > 32) ? CW : 32;

    localparam logic signed [LW-1:0] ONE_L  = LW'(1) << F;
    localparam logic signed [SW-1:0] ONE_S  = SW'(1);
    localparam logic signed [SW-1:0] HALF_G = ONE_S <<< (3 * F + 2);
    localparam logic signed [SW-1:0] HALF_J = ONE_S <<< (2 * F + 2);
    localparam logic signed [SW-1:0] HALF_D = ONE_S <<< 31;
    localparam logic signed [SW-1:0] HI32   = (ONE_S <<< 31) - ONE_S;
    localparam logic signed [SW-1:0] LO32   = -(ONE_S <<< 31);
    localparam logic signed [EW-1:0] ONE_E  = EW'(1);
    localparam logic signed [EW-1:0] HI64   = (ONE_E <<< 63) - ONE_E;
    localparam logic signed [EW-1:0] LO64   = -(ONE_E <<< 63);

    logic signed [CW-1:0]   coord_reg [24];
    logic signed [FS-1:0]   f_reg [6];
    logic signed [QW-1:0]   q_reg;
    logic signed [WW-1:0]   w_reg;
    logic signed [JW-1:0]   jac_reg [9];
    logic signed [MW-1:0]   min_reg [3];
    logic signed [31:0]     g_reg [3];
    logic signed [63:0]     det_reg;
    logic signed [AW-1:0]   a_reg;
    logic [BX-1:0]          b_reg;
    logic signed [PW-1:0]   p_reg;
    logic                   first_reg;
    logic signed [SW-1:0]   acc_reg;
    logic signed [31:0]     gx_reg, gy_reg, gz_reg;
    logic signed [63:0]     det_out_reg;
    logic                   np_reg;

    logic [4:0]             wr_base;
    logic signed [15:0]     loc [3];
    logic signed [FS-1:0]   fm [3];
    logic signed [FS-1:0]   fp [3];
    logic signed [AW-1:0]   rd;
    logic [DB-1:0]          dig;
    logic signed [DB:0]     dig_s;
    logic signed [AW+DB:0]  pd;
    logic signed [SW-1:0]   prod_e;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   g_sh;
    logic signed [31:0]     g_sat;
    logic signed [SW-1:0]   j_sh;
    logic signed [SW-1:0]   d_sh;
    logic signed [EW-1:0]   d_ext;
    logic signed [63:0]     d_sat;

    assign wr_base = 5'(node_index) * 5'd3;
    assign loc[0]  = local_r;
    assign loc[1]  = local_s;
    assign loc[2]  = local_t;

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_factor
        logic signed [LW-1:0] v;
        logic signed [LW-1:0] vc;
        assign v  = LW'(loc[ax]);
        assign vc = (v > ONE_L) ? ONE_L : ((v < -ONE_L) ? -ONE_L : v);
        assign fm[ax] = FS'(ONE_L - vc);
        assign fp[ax] = FS'(ONE_L + vc);
    end

    always_comb
    begin
        unique case (cmd.src)
            hemj_pkg::SRC_FACTOR: rd = AW'(f_reg[cmd.idx[2:0]]);
            hemj_pkg::SRC_PAIR:   rd = AW'(q_reg);
            hemj_pkg::SRC_TRIPLE: rd = AW'(w_reg);
            hemj_pkg::SRC_COORD:  rd = AW'(coord_reg[cmd.idx]);
            hemj_pkg::SRC_JAC:    rd = AW'(jac_reg[cmd.idx[3:0]]);
            hemj_pkg::SRC_MINOR:  rd = AW'(min_reg[cmd.idx[1:0]]);
            default:              rd = '0;
        endcase
    end

    assign dig    = b_reg[BX-1 -: DB];
    assign dig_s  = first_reg ? $signed({dig[DB-1], dig}) : $signed({1'b0, dig});
    assign pd     = a_reg * dig_s;
    assign prod_e = SW'(p_reg);

    always_comb
    begin
        unique case (cmd.acc_op)
            hemj_pkg::ACC_SET:     sum = prod_e;
            hemj_pkg::ACC_SET_NEG: sum = -prod_e;
            hemj_pkg::ACC_ADD:     sum = acc_reg + prod_e;
            hemj_pkg::ACC_SUB:     sum = acc_reg - prod_e;
            default:               sum = acc_reg;
        endcase
    end

    assign g_sh  = (sum + HALF_G) >>> (3 * F + 3);
    assign g_sat = (g_sh > HI32) ? 32'(HI32) : ((g_sh < LO32) ? 32'(LO32) : 32'(g_sh));
    assign j_sh  = (sum + HALF_J) >>> (2 * F + 3);
    assign d_sh  = (sum + HALF_D) >>> 32;
    assign d_ext = EW'(d_sh);
    assign d_sat = (d_ext > HI64) ? 64'(HI64) : ((d_ext < LO64) ? 64'(LO64) : 64'(d_ext));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 24; k++)
                coord_reg[k] <= '0;
        end
        else if (cmd.node_wr)
        begin
            coord_reg[wr_base]        <= CW'(CX'(node_x));
            coord_reg[wr_base + 5'd1] <= CW'(CX'(node_y));
            coord_reg[wr_base + 5'd2] <= CW'(CX'(node_z));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                f_reg[2 * ax]     <= fm[ax];
                f_reg[2 * ax + 1] <= fp[ax];
            end
        end
        if (cmd.load_a)
            a_reg <= rd;
        if (cmd.load_b)
        begin
            b_reg     <= BX'(rd);
            p_reg     <= '0;
            first_reg <= 1'b1;
        end
        if (cmd.mul_step)
        begin
            p_reg     <= (p_reg <<< DB) + PW'(pd);
            b_reg     <= b_reg << DB;
            first_reg <= 1'b0;
        end
        if (cmd.acc_op != hemj_pkg::ACC_HOLD)
            acc_reg <= sum;
        unique case (cmd.dst)
            hemj_pkg::DST_PAIR:   q_reg <= QW'(p_reg);
            hemj_pkg::DST_TRIPLE: w_reg <= WW'(p_reg);
            hemj_pkg::DST_GLOBAL: g_reg[cmd.dst_idx[1:0]] <= g_sat;
            hemj_pkg::DST_JAC:    jac_reg[cmd.dst_idx] <= JW'(j_sh);
            hemj_pkg::DST_MINOR:  min_reg[cmd.dst_idx[1:0]] <= MW'(sum);
            hemj_pkg::DST_DET:    det_reg <= d_sat;
            default: ;
        endcase
        if (cmd.out_load)
        begin
            gx_reg      <= g_reg[0];
            gy_reg      <= g_reg[1];
            gz_reg      <= g_reg[2];
            det_out_reg <= det_reg;
            np_reg      <= (det_reg <= 64'sd0);
        end
    end

    assign global_x         = gx_reg;
    assign global_y         = gy_reg;
    assign global_z         = gz_reg;
    assign jacobian_det     = det_out_reg;
    assign det_not_positive = np_reg;

endmodule

// ===== src/hex_element_map_and_jacobian.sv =====
// Top level of the eight-node hexahedron map and Jacobian determinant block.
// Depends on hemj_pkg, hemj_ctrl and hemj_dpath.
//
//  port group   dir   tdata (low bit up)                                     tuser
//  s_axis       in    node_index, node_x, node_y, node_z, local_r/s/t, pad   mode
//  m_axis       out   global_x, global_y, global_z, jacobian_det             det_not_positive
//
// A load transfer is taken whenever the block is idle; loads can follow each other every cycle while it is idle.
// An evaluation runs 225 multiplies on one shared digit-serial multiplier, each
// loading both operands, then running the digit steps, then a final accumulate step.
// The result register frees the input side; a stalled result holds only the next
// evaluation's final handoff. Reset clears the node store to zero at once.
module hex_element_map_and_jacobian #(
    parameter int COORD_WIDTH     = 32,
    parameter int LOCAL_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // node_index[2:0], node_x[34:3], node_y[66:35], node_z[98:67],
    // local_r[114:99], local_s[130:115], local_t[146:131], zero pad
    input  logic [hemj_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // mode[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // global_x[31:0], global_y[63:32], global_z[95:64], jacobian_det[159:96]
    output logic [hemj_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // det_not_positive[0]
    output logic                                 m_axis_tuser
);

    localparam int FS    = LOCAL_FRAC_BITS + 3;
    localparam int JW    = COORD_WIDTH + 4;
    localparam int BW    = (JW > FS) ? JW : FS;
    localparam int STEPS = (BW + hemj_pkg::DIGIT_BITS - 1) / hemj_pkg::DIGIT_BITS;

    hemj_pkg::cmd_t     cmd;
    logic signed [31:0] global_x, global_y, global_z;
    logic signed [63:0] jacobian_det;

    hemj_ctrl #(
        .STEPS(STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    hemj_dpath #(
        .COORD_WIDTH     (COORD_WIDTH),
        .LOCAL_FRAC_BITS (LOCAL_FRAC_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .node_index       (s_axis_tdata[2:0]),
        .node_x           (s_axis_tdata[34:3]),
        .node_y           (s_axis_tdata[66:35]),
        .node_z           (s_axis_tdata[98:67]),
        .local_r          (s_axis_tdata[114:99]),
        .local_s          (s_axis_tdata[130:115]),
        .local_t          (s_axis_tdata[146:131]),
        .global_x         (global_x),
        .global_y         (global_y),
        .global_z         (global_z),
        .jacobian_det     (jacobian_det),
        .det_not_positive (m_axis_tuser)
    );

    assign m_axis_tdata = {jacobian_det, global_z, global_y, global_x};

endmodule
